// ===== rtl/owtr_pkg.sv =====
package owtr_pkg;

    // Timer width default and config port shape
    localparam int TIMER_BITS_DEF = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT            = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_WAIT = 3'd7;

    // Config reset values
    localparam logic [9:0]  RST_RESET_LOW       = 10'd500;
    localparam logic [9:0]  RST_PRESENCE_SAMPLE = 10'd60;
    localparam logic [9:0]  RST_RESET_RECOVERY  = 10'd400;
    localparam logic [5:0]  RST_SHORT_LOW       = 6'd2;
    localparam logic [6:0]  RST_LONG_LOW        = 7'd65;
    localparam logic [5:0]  RST_READ_SAMPLE     = 6'd10;
    localparam logic [6:0]  RST_SLOT            = 7'd67;
    localparam logic [19:0] RST_CONVERSION_WAIT = 20'd750000;

    // Command bytes and byte counter milestones
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    localparam logic [2:0] BYTE_CONV_START = 3'd2;
    localparam logic [2:0] BYTE_READ_FIRST = 3'd4;
    localparam logic [2:0] BYTE_READ_END   = 3'd6;

    typedef struct packed {
        logic [9:0]  reset_low;
        logic [9:0]  presence_sample;
        logic [9:0]  reset_recovery;
        logic [5:0]  short_low;
        logic [6:0]  long_low;
        logic [5:0]  read_sample;
        logic [6:0]  slot;
        logic [19:0] conversion_wait;
    } t_cfg;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               no_presence;
        logic signed [15:0] raw_reading;
        logic signed [15:0] temperature_tenths;
    } t_res;

    // Command sequence: skip-ROM, convert, skip-ROM, read scratchpad
    function automatic logic [7:0] f_cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = CMD_SKIP_ROM;
            2'd1: b = CMD_CONVERT;
            2'd2: b = CMD_SKIP_ROM;
            2'd3: b = CMD_READ_SCRPD;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/one_wire_temperature_reader.sv =====
// Channel  | Direction | Handshake            | Payload
// tick in  | input     | i_valid / o_ready    | i_op, i_line_level
// result   | output    | o_valid / i_ready    | o_drive_low, o_busy_res, o_done_res,
//          |           |                      | o_no_presence, o_raw_reading,
//          |           |                      | o_temperature_tenths
// config   | input     | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One tick beat per cycle while the buffer has room: the sequencer step and the
// temperature scaling sit between the state registers and a two-entry result
// buffer, so each result beat is written into the buffer as its tick beat is taken.
// The buffer lets a tick beat in while one finished result still waits; the
// input stalls only when two results are held.
// Reset (synchronous, active low) returns the sequencer to idle, clears the
// reading and error flag, and loads the default bus timings.
module one_wire_temperature_reader
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tick channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic                  i_line_level,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_drive_low,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_no_presence,
    output logic signed [15:0]    o_raw_reading,
    output logic signed [15:0]    o_temperature_tenths,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;
    t_res w_res;
    t_res w_out;
    logic w_accept;
    logic w_can_push;

    // A tick beat is taken whenever the result buffer has a free slot
    assign o_ready  = w_can_push;
    assign w_accept = i_valid && w_can_push;

    // Timing registers; a write takes effect from the next tick on, even mid-sequence
    owtr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Bus sequencer: reset/presence, command bytes, conversion wait, read
    owtr_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (i_op),
        .i_line_level (i_line_level),
        .i_cfg        (w_cfg),
        .o_res        (w_res)
    );

    // Hold result beats until the consumer takes them
    owtr_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_data     (w_res),
        .o_can_push (w_can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (w_out)
    );

    assign o_drive_low          = w_out.drive_low;
    assign o_busy_res           = w_out.busy_res;
    assign o_done_res           = w_out.done_res;
    assign o_no_presence        = w_out.no_presence;
    assign o_raw_reading        = w_out.raw_reading;
    assign o_temperature_tenths = w_out.temperature_tenths;

endmodule

// ===== rtl/owtr_cfg.sv =====
module owtr_cfg
    import owtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low       <= RST_RESET_LOW;
            r_cfg.presence_sample <= RST_PRESENCE_SAMPLE;
            r_cfg.reset_recovery  <= RST_RESET_RECOVERY;
            r_cfg.short_low       <= RST_SHORT_LOW;
            r_cfg.long_low        <= RST_LONG_LOW;
            r_cfg.read_sample     <= RST_READ_SAMPLE;
            r_cfg.slot            <= RST_SLOT;
            r_cfg.conversion_wait <= RST_CONVERSION_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RESET_LOW:       r_cfg.reset_low       <= i_cfg_data[9:0];
                REG_PRESENCE_SAMPLE: r_cfg.presence_sample <= i_cfg_data[9:0];
                REG_RESET_RECOVERY:  r_cfg.reset_recovery  <= i_cfg_data[9:0];
                REG_SHORT_LOW:       r_cfg.short_low       <= i_cfg_data[5:0];
                REG_LONG_LOW:        r_cfg.long_low        <= i_cfg_data[6:0];
                REG_READ_SAMPLE:     r_cfg.read_sample     <= i_cfg_data[5:0];
                REG_SLOT:            r_cfg.slot            <= i_cfg_data[6:0];
                REG_CONVERSION_WAIT: r_cfg.conversion_wait <= i_cfg_data[19:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/owtr_core.sv =====
module owtr_core
    import owtr_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  logic i_op,
    input  logic i_line_level,
    input  t_cfg i_cfg,
    output t_res o_res
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RLOW  = 4'd1,
        PH_RREL  = 4'd2,
        PH_RREC  = 4'd3,
        PH_WRITE = 4'd4,
        PH_CONV  = 4'd5,
        PH_READ  = 4'd6
    } t_phase;

    localparam int EXT_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
    localparam logic [EXT_W-1:0] TMAX_E = EXT_W'({TIMER_BITS{1'b1}});

    // Clamp a length to [lo, 2^TIMER_BITS-1]
    function automatic logic [TIMER_BITS-1:0] f_lim(input logic [CFG_DATA_W-1:0] x,
                                                   input logic [1:0] lo);
        logic [EXT_W-1:0] xe;
        logic [EXT_W-1:0] le;
        logic [TIMER_BITS-1:0] r;
        xe = EXT_W'(x);
        le = EXT_W'(lo);
        if (xe < le) begin
            r = TIMER_BITS'(lo);
        end else if (xe > TMAX_E) begin
            r = {TIMER_BITS{1'b1}};
        end else begin
            r = xe[TIMER_BITS-1:0];
        end
        return r;
    endfunction

    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [2:0]            r_bit, n_bit;
    logic [2:0]            r_byte, n_byte;
    logic [15:0]           r_shift, n_shift;
    logic [15:0]           r_raw, n_raw;
    logic                  r_err, n_err;

    logic                  w_start;
    t_phase                w_phase;
    logic [TIMER_BITS-1:0] w_timer, w_tnext, w_len;
    logic [TIMER_BITS-1:0] w_slot, w_short, w_long, w_samp, w_low;
    logic [2:0]            w_bit, w_byte, w_bit_inc, w_byte_inc;
    logic [15:0]           w_shift;
    logic [7:0]            w_cmd;
    logic                  w_last;
    logic                  w_drive, w_done;
    logic signed [18:0]    w_raw_e, w_prod, w_adj;

    // Start request folds into this tick as tick 0 of the reset pulse
    assign w_start = (r_phase == PH_IDLE) && i_op;
    assign w_phase = w_start ? PH_RLOW : r_phase;
    assign w_timer = w_start ? '0 : r_timer;
    assign w_bit   = w_start ? 3'd0 : r_bit;
    assign w_byte  = w_start ? 3'd0 : r_byte;
    assign w_shift = w_start ? 16'd0 : r_shift;

    assign w_slot  = f_lim(CFG_DATA_W'(i_cfg.slot), 2'd2);
    assign w_short = f_lim(CFG_DATA_W'(i_cfg.short_low), 2'd1);
    assign w_long  = f_lim(CFG_DATA_W'(i_cfg.long_low), 2'd1);
    assign w_samp  = (f_lim(CFG_DATA_W'(i_cfg.read_sample), 2'd1) > (w_slot - 1'b1))
                   ? (w_slot - 1'b1) : f_lim(CFG_DATA_W'(i_cfg.read_sample), 2'd1);

    assign w_cmd = f_cmd_byte(w_byte[1:0]);
    assign w_low = w_cmd[w_bit] ? w_short : w_long;

    always_comb begin
        unique case (w_phase)
            PH_RLOW: w_len = f_lim(CFG_DATA_W'(i_cfg.reset_low), 2'd1);
            PH_RREL: w_len = f_lim(CFG_DATA_W'(i_cfg.presence_sample), 2'd1);
            PH_RREC: w_len = f_lim(CFG_DATA_W'(i_cfg.reset_recovery), 2'd1);
            PH_CONV: w_len = f_lim(i_cfg.conversion_wait, 2'd1);
            default: w_len = w_slot;
        endcase
    end

    assign w_last     = ((TIMER_BITS + 1)'(w_timer) + 1'b1) >= (TIMER_BITS + 1)'(w_len);
    assign w_tnext    = w_last ? '0 : (w_timer + 1'b1);
    assign w_bit_inc  = w_bit + 3'd1;
    assign w_byte_inc = w_byte + 3'd1;

    always_comb begin
        n_phase = w_phase;
        n_timer = w_timer;
        n_bit   = w_bit;
        n_byte  = w_byte;
        n_shift = w_shift;
        n_raw   = r_raw;
        n_err   = r_err;
        w_drive = 1'b0;
        w_done  = 1'b0;
        unique case (w_phase)
            PH_IDLE: begin
            end
            PH_RLOW: begin
                w_drive = 1'b1;
                n_timer = w_tnext;
                if (w_last) begin
                    n_phase = PH_RREL;
                end
            end
            PH_RREL: begin
                n_timer = w_tnext;
                if (w_last) begin
                    if (i_line_level) begin
                        n_err   = 1'b1;
                        w_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_bit   = 3'd0;
                        n_phase = (i_cfg.reset_recovery == '0) ? PH_WRITE : PH_RREC;
                    end
                end
            end
            PH_RREC: begin
                n_timer = w_tnext;
                if (w_last) begin
                    n_phase = PH_WRITE;
                end
            end
            PH_WRITE: begin
                w_drive = (w_timer < w_low);
                n_timer = w_tnext;
                if (w_last) begin
                    n_bit = w_bit_inc;
                    if (w_bit_inc == 3'd0) begin
                        n_byte = w_byte_inc;
                        if (w_byte_inc == BYTE_CONV_START) begin
                            n_phase = (i_cfg.conversion_wait == '0) ? PH_RLOW : PH_CONV;
                        end else if (w_byte_inc >= BYTE_READ_FIRST) begin
                            n_byte  = BYTE_READ_FIRST;
                            n_phase = PH_READ;
                        end
                    end
                end
            end
            PH_CONV: begin
                n_timer = w_tnext;
                if (w_last) begin
                    n_phase = PH_RLOW;
                end
            end
            PH_READ: begin
                w_drive = (w_timer < w_short);
                n_timer = w_tnext;
                if (w_timer == w_samp) begin
                    n_shift = w_shift | (16'(i_line_level) << {w_byte[0], w_bit});
                end
                if (w_last) begin
                    n_bit = w_bit_inc;
                    if (w_bit_inc == 3'd0) begin
                        n_byte = w_byte_inc;
                        if (w_byte_inc >= BYTE_READ_END) begin
                            n_raw   = n_shift;
                            n_err   = 1'b0;
                            w_done  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        endcase
    end

    // raw*5/8 toward zero: shift-add, bias negatives by 7 before the shift
    assign w_raw_e = $signed({{3{n_raw[15]}}, n_raw});
    assign w_prod  = (w_raw_e <<< 2) + w_raw_e;
    assign w_adj   = w_prod + (w_prod[18] ? 19'sd7 : 19'sd0);

    assign o_res.drive_low          = w_drive;
    assign o_res.busy_res           = (n_phase != PH_IDLE);
    assign o_res.done_res           = w_done;
    assign o_res.no_presence        = n_err;
    assign o_res.raw_reading        = $signed(n_raw);
    assign o_res.temperature_tenths = 16'(w_adj >>> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bit   <= 3'd0;
            r_byte  <= 3'd0;
            r_shift <= 16'd0;
            r_raw   <= 16'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_raw   <= n_raw;
            r_err   <= n_err;
        end
    end

    a_read_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_READ) |-> (r_byte == BYTE_READ_FIRST || r_byte == 3'd5))
        else $error("read phase outside the two data bytes");

    a_write_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WRITE) |-> (r_byte < BYTE_READ_FIRST))
        else $error("write phase past the command bytes");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_done) |=> (r_phase == PH_IDLE))
        else $error("sequence ended but phase not idle");

    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !w_done) |=> (r_err == $past(r_err)))
        else $error("error flag changed without a sequence end");

endmodule

// ===== rtl/owtr_out_buf.sv =====
module owtr_out_buf
    import owtr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    output logic o_can_push,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_data
);

    logic r_head_valid;
    logic r_skid_valid;
    t_res r_head;
    t_res r_skid;
    logic w_pop;
    logic w_load_head;

    assign w_pop       = r_head_valid && i_ready;
    assign w_load_head = w_pop || !r_head_valid;
    assign o_can_push  = !r_skid_valid;
    assign o_valid     = r_head_valid;
    assign o_data      = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load_head) begin
            r_head_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_head) begin
            r_head <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry held with empty head");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_pop) |=> r_skid_valid && r_head_valid)
        else $error("buffered beat lost");

endmodule

// ===== tb/one_wire_temperature_reader_tb.sv =====
module one_wire_temperature_reader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owtr_pkg::*;

    localparam int unsigned TMAX        = (1 << TIMER_BITS_DEF) - 1;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          LONG_HOLD   = 64;

    // Sequencer phases as the bus master walks through one temperature read
    typedef enum {
        PH_IDLE,
        PH_RESET_LOW,
        PH_RESET_RELEASE,
        PH_RECOVERY,
        PH_WRITE,
        PH_CONVERT,
        PH_READ
    } t_seq_phase;

    // Tracks the bus master tick by tick and keeps the result beats still owed
    class t_read_board;
        logic [9:0]  reset_low_us;
        logic [9:0]  presence_sample_us;
        logic [9:0]  reset_recovery_us;
        logic [5:0]  short_low_us;
        logic [6:0]  long_low_us;
        logic [5:0]  read_sample_us;
        logic [6:0]  slot_us;
        logic [19:0] conversion_wait_us;

        logic [7:0]  command_seq [4];
        t_seq_phase  phase;
        int unsigned timer;
        logic [2:0]  bit_pos;
        logic [2:0]  byte_pos;
        logic [15:0] shift_word;
        logic        presence;
        logic [15:0] last_raw;
        logic        error_flag;

        int unsigned done_count;
        int unsigned errors;
        int unsigned beat_count;
        t_res        awaited_beats [$];

        function new();
            reset_low_us       = RST_RESET_LOW;
            presence_sample_us = RST_PRESENCE_SAMPLE;
            reset_recovery_us  = RST_RESET_RECOVERY;
            short_low_us       = RST_SHORT_LOW;
            long_low_us        = RST_LONG_LOW;
            read_sample_us     = RST_READ_SAMPLE;
            slot_us            = RST_SLOT;
            conversion_wait_us = RST_CONVERSION_WAIT;
            command_seq = '{CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM, CMD_READ_SCRPD};
            phase      = PH_IDLE;
            timer      = 0;
            bit_pos    = '0;
            byte_pos   = '0;
            shift_word = '0;
            presence   = 1'b0;
            last_raw   = '0;
            error_flag = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RESET_LOW:       reset_low_us       = data[9:0];
                REG_PRESENCE_SAMPLE: presence_sample_us = data[9:0];
                REG_RESET_RECOVERY:  reset_recovery_us  = data[9:0];
                REG_SHORT_LOW:       short_low_us       = data[5:0];
                REG_LONG_LOW:        long_low_us        = data[6:0];
                REG_READ_SAMPLE:     read_sample_us     = data[5:0];
                REG_SLOT:            slot_us            = data[6:0];
                REG_CONVERSION_WAIT: conversion_wait_us = data[19:0];
                default: ;
            endcase
        endfunction

        function int unsigned at_least(int unsigned x, int unsigned lo);
            if (x < lo) x = lo;
            if (x > TMAX) x = TMAX;
            return x;
        endfunction

        // Count one tick of a phase of len ticks; true on its last tick
        function bit count_tick(int unsigned len);
            if (timer + 1 >= len) begin
                timer = 0;
                return 1'b1;
            end
            timer = (timer + 1) & TMAX;
            return 1'b0;
        endfunction

        function void note_tick(logic op, logic level);
            int unsigned slot_len;
            int unsigned low_len;
            int unsigned sample_idx;
            logic        cmd_bit;
            logic [3:0]  pos;
            logic        drive;
            logic        done;
            int          raw_i;
            int          tenths;
            t_res        want;
            drive    = 1'b0;
            done     = 1'b0;
            slot_len = at_least(32'(slot_us), 2);

            if (phase == PH_IDLE && op) begin
                byte_pos   = '0;
                bit_pos    = '0;
                shift_word = '0;
                presence   = 1'b0;
                phase      = PH_RESET_LOW;
                timer      = 0;
            end

            case (phase)
                PH_IDLE: ;
                PH_RESET_LOW: begin
                    drive = 1'b1;
                    if (count_tick(at_least(32'(reset_low_us), 1))) phase = PH_RESET_RELEASE;
                end
                PH_RESET_RELEASE: begin
                    if (count_tick(at_least(32'(presence_sample_us), 1))) begin
                        presence = !level;
                        if (!presence) begin
                            error_flag = 1'b1;
                            done       = 1'b1;
                            phase      = PH_IDLE;
                        end else begin
                            bit_pos = '0;
                            phase   = (reset_recovery_us == 0) ? PH_WRITE : PH_RECOVERY;
                        end
                    end
                end
                PH_RECOVERY: begin
                    if (count_tick(at_least(32'(reset_recovery_us), 1))) phase = PH_WRITE;
                end
                PH_WRITE: begin
                    cmd_bit = command_seq[byte_pos[1:0]][bit_pos];
                    low_len = cmd_bit ? at_least(32'(short_low_us), 1)
                                      : at_least(32'(long_low_us), 1);
                    drive   = (timer < low_len);
                    if (count_tick(slot_len)) begin
                        bit_pos = bit_pos + 3'd1;
                        if (bit_pos == 3'd0) begin
                            byte_pos = byte_pos + 3'd1;
                            if (byte_pos == BYTE_CONV_START) begin
                                timer = 0;
                                phase = (conversion_wait_us == 0) ? PH_RESET_LOW : PH_CONVERT;
                            end else if (byte_pos >= BYTE_READ_FIRST) begin
                                byte_pos = BYTE_READ_FIRST;
                                phase    = PH_READ;
                            end
                        end
                    end
                end
                PH_CONVERT: begin
                    if (count_tick(at_least(32'(conversion_wait_us), 1))) begin
                        phase = PH_RESET_LOW;
                        timer = 0;
                    end
                end
                PH_READ: begin
                    sample_idx = at_least(32'(read_sample_us), 1);
                    if (sample_idx > slot_len - 1) sample_idx = slot_len - 1;
                    drive = (timer < at_least(32'(short_low_us), 1));
                    if (timer == sample_idx) begin
                        pos = {byte_pos[0], bit_pos};
                        if (level) shift_word[pos] = 1'b1;
                    end
                    if (count_tick(slot_len)) begin
                        bit_pos = bit_pos + 3'd1;
                        if (bit_pos == 3'd0) begin
                            byte_pos = byte_pos + 3'd1;
                            if (byte_pos >= BYTE_READ_END) begin
                                last_raw   = shift_word;
                                error_flag = 1'b0;
                                done       = 1'b1;
                                phase      = PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    timer = 0;
                end
            endcase

            raw_i  = int'($signed(last_raw));
            tenths = (raw_i * 5) / 8;
            want.drive_low          = drive;
            want.busy_res           = (phase != PH_IDLE);
            want.done_res           = done;
            want.no_presence        = error_flag;
            want.raw_reading        = last_raw;
            want.temperature_tenths = tenths[15:0];
            awaited_beats.push_back(want);
            if (done) done_count++;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("mismatch: %s", what);
        endtask

        task check_result(t_res got);
            t_res  want;
            string diff;
            beat_count++;
            if (awaited_beats.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", beat_count));
                return;
            end
            want = awaited_beats.pop_front();
            diff = "";
            if (got.drive_low !== want.drive_low) diff = {diff, " drive_low"};
            if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
            if (got.done_res !== want.done_res) diff = {diff, " done_res"};
            if (got.no_presence !== want.no_presence) diff = {diff, " no_presence"};
            if (got.raw_reading !== want.raw_reading) diff = {diff, " raw_reading"};
            if (got.temperature_tenths !== want.temperature_tenths)
                diff = {diff, " temperature_tenths"};
            if (diff != "")
                report($sformatf("beat %0d%s: got %b%b%b%b %0d %0d, want %b%b%b%b %0d %0d",
                    beat_count, diff, got.drive_low, got.busy_res, got.done_res,
                    got.no_presence, got.raw_reading, got.temperature_tenths,
                    want.drive_low, want.busy_res, want.done_res, want.no_presence,
                    want.raw_reading, want.temperature_tenths));
        endtask

        function int pending();
            return awaited_beats.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_op = 1'b0;
    logic                  i_line_level = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_drive_low;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_no_presence;
    logic signed [15:0]    o_raw_reading;
    logic signed [15:0]    o_temperature_tenths;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    one_wire_temperature_reader i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_op                 (i_op),
        .i_line_level         (i_line_level),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_drive_low          (o_drive_low),
        .o_busy_res           (o_busy_res),
        .o_done_res           (o_done_res),
        .o_no_presence        (o_no_presence),
        .o_raw_reading        (o_raw_reading),
        .o_temperature_tenths (o_temperature_tenths),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    t_read_board board = new();

    // Stimulus knobs, changed by the main sequence between phases
    bit          calm = 1'b0;          // no idling on either side
    int          start_pct_idle = 30;  // chance of a start request while idle
    int          start_pct_busy = 6;   // chance of a stray start while busy
    int          answer_pct = 92;      // chance the sensor holds the bus low for presence
    bit          use_target = 1'b0;    // read slots return raw_target instead of noise
    logic [15:0] raw_target = '0;
    int          hold_requests = 0;    // bumped to ask the receiver for a long hold-off
    int          hold_served = 0;
    int          ready_wait = 0;
    int unsigned ticks_sent = 0;
    int unsigned cycles = 0;

    always #6 i_clk = ~i_clk;

    // Sample both channels at the rising edge, before any register of the block moves
    always @(posedge i_clk) begin : beat_monitor
        t_res got;
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_tick(i_op, i_line_level);
            if (o_valid && i_ready) begin
                got = '{o_drive_low, o_busy_res, o_done_res, o_no_presence,
                        o_raw_reading, o_temperature_tenths};
                board.check_result(got);
            end
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random ready gaps, mostly short, plus a long hold-off on request
    always @(negedge i_clk) begin : ready_driver
        int pick;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            // hold off long enough for the result buffer to fill and stall the ticks
            hold_served = hold_requests;
            ready_wait  = LONG_HOLD;
            i_ready <= 1'b0;
        end else if (ready_wait > 0) begin
            ready_wait--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                ready_wait = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(3, 20);
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 70) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Act as the sensor: pull low for presence, answer read slots, noise elsewhere
    function automatic logic sensor_level();
        case (board.phase)
            PH_RESET_RELEASE: return !($urandom_range(0, 99) < answer_pct);
            PH_READ: begin
                if (use_target) return raw_target[{board.byte_pos[0], board.bit_pos}];
                return 1'($urandom_range(0, 1));
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [19:0] with_junk(int unsigned value, int width);
        logic [19:0] junk;
        junk = 20'($urandom());
        return (junk << width) | value[19:0];
    endfunction

    // Offer one tick beat; call at a falling edge, returns at a falling edge.
    // Keep valid high across back-to-back beats; drop it only for a gap.
    task automatic send_tick(input logic op, input logic level);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_line_level <= level;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    task automatic tick_once();
        int   pct;
        logic op;
        pct = (board.phase == PH_IDLE) ? start_pct_idle : start_pct_busy;
        op  = ($urandom_range(0, 99) < pct);
        send_tick(op, sensor_level());
        ticks_sent++;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) tick_once();
    endtask

    task automatic run_until_done(input int n);
        int unsigned goal;
        goal = board.done_count + n;
        while (board.done_count < goal) tick_once();
    endtask

    // Stop offering and wait for every owed result beat
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_timing(input logic [19:0] rst_low, input logic [19:0] pres,
                               input logic [19:0] recov, input logic [19:0] short_low,
                               input logic [19:0] long_low, input logic [19:0] rd_sample,
                               input logic [19:0] slot, input logic [19:0] conv);
        cfg_write(REG_RESET_LOW, rst_low);
        cfg_write(REG_PRESENCE_SAMPLE, pres);
        cfg_write(REG_RESET_RECOVERY, recov);
        cfg_write(REG_SHORT_LOW, short_low);
        cfg_write(REG_LONG_LOW, long_low);
        cfg_write(REG_READ_SAMPLE, rd_sample);
        cfg_write(REG_SLOT, slot);
        cfg_write(REG_CONVERSION_WAIT, conv);
    endtask

    initial begin : main_seq
        logic [15:0] raw_corner [5];
        int unsigned directed_ticks;
        int unsigned slot;
        bit          first_epoch;
        raw_corner  = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFF8, 16'h0008};
        first_epoch = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default timings: a few idle ticks, then a read with no sensor answering
        start_pct_idle = 0;
        run_ticks(6);
        start_pct_idle = 100;
        start_pct_busy = 10;
        answer_pct     = 0;
        run_until_done(1);
        drain();

        // All lengths zero: every timing clamps to its floor and both waits are skipped
        load_timing('0, '0, '0, '0, '0, '0, '0, '0);
        answer_pct     = 100;
        start_pct_busy = 25;
        use_target     = 1'b1;
        foreach (raw_corner[k]) begin
            raw_target = raw_corner[k];
            run_until_done(1);
        end
        drain();

        // Low times past the slot, read sample past the slot, then a missing
        // presence followed by a good read that clears the flag
        load_timing(20'd1, 20'd1, 20'd2, 20'd10, 20'd127, 20'd63, 20'd3, 20'd1);
        raw_target = 16'h5A5A;
        answer_pct = 0;
        run_until_done(1);
        answer_pct = 100;
        run_until_done(1);
        drain();

        // Every register at its maximum: hold the reset pulse a while, then shorten
        // the bus waits on the fly; run one full-length slot, then shrink the slot,
        // and cut the conversion wait short once it starts
        load_timing('1, '1, '1, '1, '1, '1, '1, '1);
        raw_target     = 16'($urandom());
        start_pct_busy = 2;
        run_ticks(40);
        drain();
        cfg_write(REG_RESET_LOW, 20'd1);
        cfg_write(REG_PRESENCE_SAMPLE, 20'd1);
        cfg_write(REG_RESET_RECOVERY, 20'd1);
        while (board.phase != PH_WRITE) tick_once();
        run_ticks(130);
        drain();
        cfg_write(REG_SLOT, 20'd4);
        while (board.phase != PH_CONVERT) tick_once();
        run_ticks(10);
        drain();
        cfg_write(REG_CONVERSION_WAIT, 20'd3);
        run_until_done(1);
        drain();
        directed_ticks = ticks_sent;

        // Random epochs: short timings with random content, sensor mostly answering
        use_target = 1'b0;
        while (ticks_sent - directed_ticks < 500) begin
            slot = $urandom_range(0, 8);
            load_timing(with_junk($urandom_range(0, 12), 10),
                        with_junk($urandom_range(0, 8), 10),
                        with_junk($urandom_range(0, 10), 10),
                        with_junk($urandom_range(0, slot + 2), 6),
                        with_junk($urandom_range(0, slot + 3), 7),
                        with_junk($urandom_range(0, slot + 2), 6),
                        with_junk(slot, 7),
                        with_junk($urandom_range(0, 25), 20));
            calm           = ($urandom_range(0, 4) == 0);
            start_pct_idle = 30;
            start_pct_busy = 6;
            answer_pct     = 92;
            run_ticks($urandom_range(10, 80));
            if (first_epoch || $urandom_range(0, 3) == 0) begin
                // receiver goes quiet while ticks keep coming
                calm = 1'b0;
                hold_requests++;
            end else if ($urandom_range(0, 2) == 0) begin
                // sender pauses mid-sequence until all results are back
                drain();
            end
            first_epoch = 1'b0;
            run_until_done($urandom_range(1, 3));
            drain();
        end

        calm = 1'b0;
        drain();
        repeat (4) @(negedge i_clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d result beats never arrived", board.pending()));
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
